@@ rtl/egcd_pkg.sv @@
package egcd_pkg;

    // Round a bit count up to whole bytes, for stream tdata widths
    function automatic int pad_to_bytes(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

@@ rtl/extended_gcd_bezout.sv @@
// Sequence: the operands are accepted in idle, then each quotient step runs a bit-serial
// restoring division and an update; the result goes out once the output beat is free.
// Throughput: one operand pair at a time; about 46 quotient steps worst case at
// WIDTH=32. The single shared divide step sets this.
// A zero second operand skips the divide loop and finishes with the error flag set.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops m_tvalid.
module extended_gcd_bezout
    import egcd_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata: first_operand [WIDTH-2:0], second_operand [2*WIDTH-3:WIDTH-1], zero pad
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pad_to_bytes(2*WIDTH-2)-1:0]     s_tdata,
    // m_tdata: divisor [WIDTH-2:0], first_coef [2*WIDTH-2:WIDTH-1],
    //          second_coef [3*WIDTH-2:2*WIDTH-1], zero pad
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pad_to_bytes(3*WIDTH-1)-1:0]     m_tdata,
    // m_tuser: zero_error
    output logic                                   m_tuser
);

    localparam int OW       = WIDTH - 1;
    localparam int OUT_BITS = pad_to_bytes(3*WIDTH-1);
    localparam int CW       = $clog2(WIDTH - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 2);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_STEP} state_t;

    state_t               state_reg, state_next;
    logic [OW-1:0]        num_reg, num_next;
    logic [OW-1:0]        den_reg, den_next;
    logic [OW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WIDTH-1:0]     xa_reg, xa_next, xb_reg, xb_next;
    logic [WIDTH-1:0]     ya_reg, ya_next, yb_reg, yb_next;
    logic [WIDTH-1:0]     accx_reg, accx_next, accy_reg, accy_next;
    logic                 err_reg, err_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_BITS-1:0]  m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic [OW:0]          trial;
    logic [OW:0]          diff;
    logic                 qbit;
    logic                 out_free;
    logic [OW-1:0]        in_a, in_b;

    assign in_a = s_tdata[OW-1:0];
    assign in_b = s_tdata[2*OW-1:OW];

    // Shared divide step: shift in one dividend bit, trial subtract
    assign trial = {rem_reg, num_reg[OW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        xa_next       = xa_reg;
        xb_next       = xb_reg;
        ya_next       = ya_reg;
        yb_next       = yb_reg;
        accx_next     = accx_reg;
        accy_next     = accy_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    num_next  = in_a;
                    den_next  = in_b;
                    rem_next  = '0;
                    cnt_next  = '0;
                    accx_next = '0;
                    accy_next = '0;
                    xa_next   = WIDTH'(1);
                    ya_next   = '0;
                    xb_next   = '0;
                    if (in_b == '0)
                    begin
                        // nothing to divide by: report zeros with the error flag
                        yb_next    = '0;
                        err_next   = 1'b1;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        yb_next    = WIDTH'(1);
                        err_next   = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // quotient bits come MSB first; Horner-accumulate q*xb and q*yb
                rem_next  = qbit ? diff[OW-1:0] : trial[OW-1:0];
                num_next  = {num_reg[OW-2:0], 1'b0};
                accx_next = {accx_reg[WIDTH-2:0], 1'b0} + (qbit ? xb_reg : '0);
                accy_next = {accy_reg[WIDTH-2:0], 1'b0} + (qbit ? yb_reg : '0);
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                if (rem_reg == '0)
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = OUT_BITS'({yb_reg, xb_reg, den_reg});
                        m_tuser_next  = err_reg;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    // rotate operands and coefficients for the next quotient step
                    num_next   = den_reg;
                    den_next   = rem_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    accx_next  = '0;
                    accy_next  = '0;
                    xa_next    = xb_reg;
                    xb_next    = xa_reg - accx_reg;
                    ya_next    = yb_reg;
                    yb_next    = ya_reg - accy_reg;
                    state_next = ST_DIV;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            num_reg      <= '0;
            den_reg      <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            xa_reg       <= '0;
            xb_reg       <= '0;
            ya_reg       <= '0;
            yb_reg       <= '0;
            accx_reg     <= '0;
            accy_reg     <= '0;
            err_reg      <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
            rem_reg      <= rem_next;
            cnt_reg      <= cnt_next;
            xa_reg       <= xa_next;
            xb_reg       <= xb_next;
            ya_reg       <= ya_next;
            yb_reg       <= yb_next;
            accx_reg     <= accx_next;
            accy_reg     <= accy_next;
            err_reg      <= err_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Partial remainder always stays below the divisor while dividing
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

    // A zero second operand skips the divide loop
    a_zero_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && in_b == '0 |=> state_reg == ST_STEP && err_reg)
        else $error("zero operand did not go straight to result");

    // Error beats carry all-zero payload
    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error beat with nonzero data");

    // A good result never has a zero gcd
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[OW-1:0] != '0)
        else $error("zero gcd without error flag");

endmodule
